// ----- rtl/utf8_sentence_segmenter_defines.svh -----
// assertion macros used by the segmenter top level
`ifndef UTF8_SENTENCE_SEGMENTER_DEFINES_SVH
`define UTF8_SENTENCE_SEGMENTER_DEFINES_SVH

// same-cycle implication, muted while reset is high
`define USSG_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("segmenter check failed");

// next-cycle implication, muted while reset is high
`define USSG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("segmenter check failed");

`endif

// ----- rtl/ussg_pkg.sv -----
package ussg_pkg;

   localparam logic [7:0] MIN_SEGMENT_RESET = 8'd48;

   // ascii delimiters and whitespace
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
   localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   // three-byte delimiters
   localparam logic [23:0] WIDE_FULL_STOP   = 24'hE38082;
   localparam logic [23:0] WIDE_COMMA       = 24'hE38081;
   localparam logic [23:0] WIDE_QUESTION    = 24'hEFBC9F;
   localparam logic [23:0] WIDE_EXCLAIM     = 24'hEFBC81;
   localparam logic [23:0] WIDE_PERIOD      = 24'hEFBC8E;

   // lead byte masks
   localparam logic [7:0] LEAD_ASCII_BIT = 8'h80;
   localparam logic [7:0] LEAD2_MASK     = 8'hE0;
   localparam logic [7:0] LEAD2_CODE     = 8'hC0;
   localparam logic [7:0] LEAD3_MASK     = 8'hF0;
   localparam logic [7:0] LEAD3_CODE     = 8'hE0;
   localparam logic [7:0] LEAD4_MASK     = 8'hF8;
   localparam logic [7:0] LEAD4_CODE     = 8'hF0;

   // output saturation
   localparam logic [15:0] START_LIMIT = 16'hFFFF;
   localparam logic [16:0] END_LIMIT   = 17'h10000;

   typedef struct packed {
      logic complete;
      logic delim;
      logic hard;
   } char_info_type;

   typedef struct packed {
      logic        overflow;
      logic        done;
      logic        append;
      logic [16:0] seg_end;
      logic [15:0] seg_start;
      logic        valid;
   } result_type;

   function automatic logic [2:0] char_length(input logic [7:0] lead);
      logic [2:0] len;
      if ((lead & LEAD_ASCII_BIT) == 8'h00) begin
         len = 3'd1;
      end else if ((lead & LEAD2_MASK) == LEAD2_CODE) begin
         len = 3'd2;
      end else if ((lead & LEAD3_MASK) == LEAD3_CODE) begin
         len = 3'd3;
      end else if ((lead & LEAD4_MASK) == LEAD4_CODE) begin
         len = 3'd4;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic wide_delimiter(input logic [23:0] v);
      return (v == WIDE_FULL_STOP) || (v == WIDE_COMMA) || (v == WIDE_QUESTION) ||
             (v == WIDE_EXCLAIM) || (v == WIDE_PERIOD);
   endfunction

endpackage

// ----- rtl/ussg_char_decoder.sv -----
module ussg_char_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              text_byte,
   input  logic                    last_byte,
   output ussg_pkg::char_info_type char_info
);

   logic [1:0]  left_ff, left_in;
   logic [15:0] pending_ff, pending_in;
   logic        three_ff, three_in;
   logic [2:0]  len;

   always_comb begin
      len        = ussg_pkg::char_length(text_byte);
      left_in    = left_ff;
      pending_in = pending_ff;
      three_in   = three_ff;
      char_info  = '0;
      if (left_ff == 2'd0) begin
         if (len == 3'd1) begin
            char_info.complete = 1'b1;
            char_info.hard     = (text_byte == ussg_pkg::CHAR_NEWLINE);
            char_info.delim    = char_info.hard ||
                                 (text_byte == ussg_pkg::CHAR_QUESTION) ||
                                 (text_byte == ussg_pkg::CHAR_EXCLAIM) ||
                                 (text_byte == ussg_pkg::CHAR_PERIOD);
         end else begin
            left_in    = 2'(len - 3'd1);
            pending_in = {8'h00, text_byte};
            three_in   = (len == 3'd3);
         end
      end else begin
         left_in    = left_ff - 2'd1;
         pending_in = {pending_ff[7:0], text_byte};
         if (left_ff == 2'd1) begin
            char_info.complete = 1'b1;
            char_info.delim    = three_ff &&
                                 ussg_pkg::wide_delimiter({pending_ff, text_byte});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= 2'd0;
         pending_ff <= '0;
         three_ff   <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            left_ff    <= 2'd0;
            pending_ff <= '0;
            three_ff   <= 1'b0;
         end else begin
            left_ff    <= left_in;
            pending_ff <= pending_in;
            three_ff   <= three_in;
         end
      end
   end

endmodule

// ----- rtl/ussg_segment_tracker.sv -----
module ussg_segment_tracker #(
   parameter int MAX_TEXT_BYTES = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              text_byte,
   input  logic                    last_byte,
   input  ussg_pkg::char_info_type char_info,
   input  logic [7:0]              min_segment_bytes,
   output logic                    emit,
   output ussg_pkg::result_type    result
);

   localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
   localparam int EXT_W = (POS_W > 17) ? POS_W : 17;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_BYTES);

   logic [POS_W-1:0] pos_ff, open_ff, first_ff, last_ff;
   logic             has_ff, any_ff, ovf_ff;

   logic [POS_W-1:0] idx, end_pos, span, tail_len, kept_first, kept_end;
   logic [POS_W-1:0] min_ext;
   logic [EXT_W-1:0] start_ext, end_ext;
   logic             at_limit, kept, has_k, close, ovf_in;

   always_comb begin
      at_limit   = (pos_ff >= MAX_POS);
      ovf_in     = ovf_ff | at_limit;
      idx        = at_limit ? (MAX_POS - POS_W'(1)) : pos_ff;
      end_pos    = idx + POS_W'(1);
      kept       = !ussg_pkg::is_space(text_byte);
      kept_first = (kept && !has_ff) ? idx : first_ff;
      kept_end   = kept ? end_pos : last_ff;
      has_k      = has_ff | kept;
      min_ext    = {{(POS_W-8){1'b0}}, min_segment_bytes};
      span       = end_pos - open_ff;
      tail_len   = kept_end - kept_first;
      close      = char_info.complete && char_info.delim &&
                   (char_info.hard || !any_ff || (span >= min_ext));
      emit       = (close && has_k) || last_byte;

      start_ext  = EXT_W'(kept_first);
      end_ext    = EXT_W'(kept_end);
      result     = '0;
      result.done     = last_byte;
      result.overflow = ovf_in;
      result.valid    = has_k;
      if (has_k) begin
         result.seg_start = (start_ext > EXT_W'(ussg_pkg::START_LIMIT)) ?
                            ussg_pkg::START_LIMIT : start_ext[15:0];
         result.seg_end   = (end_ext > EXT_W'(ussg_pkg::END_LIMIT)) ?
                            ussg_pkg::END_LIMIT : end_ext[16:0];
         result.append    = !close && any_ff && (tail_len < min_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         open_ff  <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         has_ff   <= 1'b0;
         any_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            pos_ff   <= '0;
            open_ff  <= '0;
            first_ff <= '0;
            last_ff  <= '0;
            has_ff   <= 1'b0;
            any_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            pos_ff   <= end_pos;
            first_ff <= kept_first;
            last_ff  <= kept_end;
            ovf_ff   <= ovf_in;
            if (close) begin
               open_ff <= end_pos;
               has_ff  <= 1'b0;
               any_ff  <= any_ff | has_k;
            end else begin
               has_ff  <= has_k;
            end
         end
      end
   end

endmodule

// ----- rtl/utf8_sentence_segmenter.sv -----
// UTF-8 sentence segmenter. Text enters one byte per transfer on req_ (req_tlast on the
// final byte) and leaves as segments given by byte offsets, ASCII whitespace trimmed.
// A newline always closes a segment; the first segment closes at any delimiter
// (ideographic full stop or comma, fullwidth ? ! ., or ASCII ? ! .) and later ones only
// once their untrimmed length reaches min_segment_bytes, set through csr_we/csr_wdata
// (reset 48) while the block is idle. Empty segments produce no transfer, except that
// the final byte always yields exactly one rsp_ transfer with rsp_tlast set, carrying
// the closed segment, the trimmed tail (append flag set when short and not the first
// segment) or an empty marker. One byte is taken every cycle while rsp_tready is high:
// an input register feeds a single pass of character decode and offset tracking into
// the result register. Texts longer than MAX_TEXT_BYTES raise the overflow flag and
// saturate offsets.
`include "utf8_sentence_segmenter_defines.svh"

module utf8_sentence_segmenter #(
   parameter int MAX_TEXT_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,     // min_segment_bytes
   // text byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] text_byte
   input  logic        req_tlast,     // last_byte
   // segment stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [15:0] segment_start, [32:16] segment_end, rest zero
   output logic [2:0]  rsp_tuser,     // [0] segment_valid, [1] append_to_previous,
                                      // [2] length_overflow
   output logic        rsp_tlast      // text_done
);

   // configuration register
   logic [7:0] min_ff;

   // input register stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register stage
   logic                 rsp_valid_ff;
   ussg_pkg::result_type rsp_ff;

   ussg_pkg::char_info_type char_info;
   ussg_pkg::result_type    result;
   logic                    emit;
   logic                    step;

   // the held byte is processed whenever the result register is free or draining
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= ussg_pkg::MIN_SEGMENT_RESET;
      end else if (csr_we) begin
         min_ff <= csr_wdata;
      end
   end

   // input register: payload loads on every accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ussg_char_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .char_info (char_info)
   );

   ussg_segment_tracker #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_tracker (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .text_byte         (in_byte_ff),
      .last_byte         (in_last_ff),
      .char_info         (char_info),
      .min_segment_bytes (min_ff),
      .emit              (emit),
      .result            (result)
   );

   // result register: a byte that closes nothing leaves it empty
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.seg_end, rsp_ff.seg_start};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.append, rsp_ff.valid};
   assign rsp_tlast  = rsp_ff.done;

   // an empty marker only ever ends a text
   `USSG_ASSERT_IMPLY(a_empty_only_at_end, clock, reset,
      rsp_tvalid && !rsp_tuser[0], rsp_tlast && rsp_tdata == 40'd0 && !rsp_tuser[1])
   // append applies only to a real tail on the final byte
   `USSG_ASSERT_IMPLY(a_append_is_tail, clock, reset,
      rsp_tvalid && rsp_tuser[1], rsp_tlast && rsp_tuser[0])
   // a kept segment is never empty
   `USSG_ASSERT_IMPLY(a_segment_nonempty, clock, reset,
      rsp_tvalid && rsp_tuser[0], rsp_tdata[32:16] > {1'b0, rsp_tdata[15:0]})
   // a processed byte with a result lands in the output register
   `USSG_ASSERT_NEXT(a_emit_lands, clock, reset,
      step && emit, rsp_tvalid)

endmodule
